### sv/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared types and constants of the UBX frame deframer.
// ----------------------------------------------------------------------------
package ufd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [7:0] NAV_ID_GEO_POS = 8'h02;
    localparam logic [7:0] NAV_ID_SOL     = 8'h06;
    localparam logic [7:0] NAV_ID_VELNED  = 8'h12;
    localparam logic [7:0] NAV_ID_SVINFO  = 8'h30;
    localparam logic [7:0] NAV_ID_STATUS  = 8'h03;
    localparam logic [7:0] NAV_ID_CLOCK   = 8'h22;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAV_CLASS = 2'd1;

    localparam logic [15:0] MAX_LEN_RESET   = 16'd992;
    localparam logic [7:0]  NAV_CLASS_RESET = 8'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_LONG    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        NAV_OTHER   = 3'd0,
        NAV_GEO_POS = 3'd1,
        NAV_SOL     = 3'd2,
        NAV_VELNED  = 3'd3,
        NAV_SVINFO  = 3'd4,
        NAV_STATUS  = 3'd5,
        NAV_CLOCK   = 3'd6
    } nav_t;

    typedef enum logic [3:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } phase_t;

    // One classified event, passed from the parser to the output stage.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] index;
        logic [7:0]  data;
        logic [15:0] length;
    } entry_t;

    // Queue handshake seen by the parser.
    typedef struct packed {
        logic   push;
        entry_t data;
    } push_t;

endpackage

### sv/ufd_byte_if.sv
// ----------------------------------------------------------------------------
// ufd_byte_if
// Received byte channel: valid, ready and one byte.
// ----------------------------------------------------------------------------
interface ufd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/ufd_result_if.sv
// ----------------------------------------------------------------------------
// ufd_result_if
// Result channel: valid, ready and the decoded result fields.
// ----------------------------------------------------------------------------
interface ufd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic [2:0]  nav_message;

    modport source (output valid, output result_kind, output msg_class, output msg_id,
                    output payload_index, output payload_byte, output payload_length,
                    output nav_message, input ready);
    modport sink   (input valid, input result_kind, input msg_class, input msg_id,
                    input payload_index, input payload_byte, input payload_length,
                    input nav_message, output ready);
endinterface

### sv/ufd_cfg_if.sv
// ----------------------------------------------------------------------------
// ufd_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface ufd_cfg_if;
    import ufd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/ubx_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// ubx_frame_deframer_top
// UBX frame deframer: sync hunt, header decode, payload pass-through and
// 8-bit Fletcher check, with a short queue between parser and output.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | carries
//  --------+-----+-------------+--------------------------------------------
//  rx      | in  | valid/ready | rx_byte, one item per stream byte
//  res     | out | valid/ready | kind, class, id, index, byte, length, nav
//  cfg     | in  | valid/ready | index 0 max payload length, 1 nav class
//
//  One byte is taken every cycle while the queue has room; a result passes
//  from the parser into the queue, then into the output register.
//  rst_n clears parser, queue and output valid at once and loads the
//  register defaults (992, class 1); no clearing pass is needed.
//  A stalled result waits in the output register while the queue keeps
//  taking events; rx.ready drops only once the four-entry queue is full.
//  cfg.ready is always high; write configuration only while idle.
//
module ubx_frame_deframer_top (
    input  logic         clk,
    input  logic         rst_n,
    ufd_byte_if.sink     rx,
    ufd_result_if.source res,
    ufd_cfg_if.sink      cfg
);
    import ufd_pkg::*;

    logic [15:0] max_len_reg;
    logic [7:0]  nav_class_reg;

    push_t       q_push;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    entry_t      q_data;

    // Configuration registers: always ready, ignore unknown indexes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            nav_class_reg <= NAV_CLASS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_MAX_LEN)
                max_len_reg <= cfg.data;
            if (cfg.index == CFG_NAV_CLASS)
                nav_class_reg <= cfg.data[7:0];
        end
    end

    // Front: classify each byte and push any event it causes.
    ufd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .max_len (max_len_reg),
        .q_full  (q_full),
        .q_push  (q_push)
    );

    // Queue: decouple the parser from a stalled result consumer.
    ufd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_push  (q_push),
        .full     (q_full),
        .pop      (q_pop),
        .out_data (q_data),
        .empty    (q_empty)
    );

    // Back: code the nav message and hold the result until taken.
    ufd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .nav_class (nav_class_reg),
        .res       (res)
    );

endmodule

### sv/ufd_front.sv
// ----------------------------------------------------------------------------
// ufd_front
// Frame parser: takes one byte a cycle unless the queue is full, tracks the
// frame, runs the Fletcher sums and pushes each classified event into the queue.
// ----------------------------------------------------------------------------
module ufd_front (
    input  logic          clk,
    input  logic          rst_n,
    ufd_byte_if.sink      rx,
    input  logic [15:0]   max_len,
    input  logic          q_full,
    output ufd_pkg::push_t q_push
);
    import ufd_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  class_reg,  class_next;
    logic [7:0]  id_reg,     id_next;
    logic [15:0] len_reg,    len_next;
    logic [15:0] count_reg,  count_next;
    logic [7:0]  sum_a_reg,  sum_a_next;
    logic [7:0]  sum_b_reg,  sum_b_next;
    logic [7:0]  recv_a_reg, recv_a_next;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  fold_a;
    logic [7:0]  fold_b;
    logic [15:0] len_full;
    logic [15:0] count_inc;

    assign rx.ready  = !q_full;
    assign accept    = rx.valid && rx.ready;
    assign b         = rx.rx_byte;
    assign fold_a    = sum_a_reg + b;
    assign fold_b    = sum_b_reg + fold_a;
    assign len_full  = {b, len_reg[7:0]};
    assign count_inc = count_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            class_reg  <= '0;
            id_reg     <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            recv_a_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            recv_a_reg <= recv_a_next;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        class_next         = class_reg;
        id_next            = id_reg;
        len_next           = len_reg;
        count_next         = count_reg;
        sum_a_next         = sum_a_reg;
        sum_b_next         = sum_b_reg;
        recv_a_next        = recv_a_reg;
        q_push.push        = 1'b0;
        q_push.data.kind   = KIND_PAYLOAD;
        q_push.data.msg_class = class_reg;
        q_push.data.msg_id = id_reg;
        q_push.data.index  = '0;
        q_push.data.data   = '0;
        q_push.data.length = len_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (b == SYNC_FIRST)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    if (b == SYNC_SECOND)
                    begin
                        sum_a_next = '0;
                        sum_b_next = '0;
                        phase_next = PH_CLASS;
                    end
                    else if (b != SYNC_FIRST)
                        phase_next = PH_HUNT1;
                end
                PH_CLASS:
                begin
                    class_next = b;
                    sum_a_next = fold_a;
                    sum_b_next = fold_b;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next    = b;
                    sum_a_next = fold_a;
                    sum_b_next = fold_b;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {8'h00, b};
                    sum_a_next = fold_a;
                    sum_b_next = fold_b;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = len_full;
                    sum_a_next = fold_a;
                    sum_b_next = fold_b;
                    count_next = '0;
                    if (len_full > max_len)
                    begin
                        // drop the frame and report it at once
                        q_push.push        = 1'b1;
                        q_push.data.kind   = KIND_LONG;
                        q_push.data.length = len_full;
                        phase_next         = PH_HUNT1;
                    end
                    else if (len_full == 16'd0)
                        phase_next = PH_CK_A;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    q_push.push       = 1'b1;
                    q_push.data.index = count_reg;
                    q_push.data.data  = b;
                    sum_a_next        = fold_a;
                    sum_b_next        = fold_b;
                    count_next        = count_inc;
                    if (count_inc >= len_reg)
                        phase_next = PH_CK_A;
                end
                PH_CK_A:
                begin
                    recv_a_next = b;
                    phase_next  = PH_CK_B;
                end
                PH_CK_B:
                begin
                    q_push.push      = 1'b1;
                    q_push.data.kind = (recv_a_reg == sum_a_reg && b == sum_b_reg)
                                       ? KIND_GOOD : KIND_BAD;
                    phase_next       = PH_HUNT1;
                end
                default:
                    phase_next = PH_HUNT1;
            endcase
        end
    end

endmodule

### sv/ufd_fifo.sv
// ----------------------------------------------------------------------------
// ufd_fifo
// Short event queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module ufd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  ufd_pkg::push_t in_push,
    output logic           full,
    input  logic           pop,
    output ufd_pkg::entry_t out_data,
    output logic           empty
);
    import ufd_pkg::*;

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg,   fill_next;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (fill_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = in_push.push && !full;
    assign do_pop   = pop && !empty;
    assign out_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= in_push.data;
    end

endmodule

### sv/ufd_back.sv
// ----------------------------------------------------------------------------
// ufd_back
// Output stage: pops events, codes the nav message and holds the result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module ufd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ufd_pkg::entry_t q_data,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic [7:0]      nav_class,
    ufd_result_if.source    res
);
    import ufd_pkg::*;

    logic        valid_reg, valid_next;
    kind_t       kind_reg;
    logic [7:0]  class_reg;
    logic [7:0]  id_reg;
    logic [15:0] index_reg;
    logic [7:0]  data_reg;
    logic [15:0] len_reg;
    nav_t        nav_reg;
    nav_t        nav_code;

    always_comb
    begin
        nav_code = NAV_OTHER;
        if (q_data.msg_class == nav_class)
        begin
            unique case (q_data.msg_id)
                NAV_ID_GEO_POS: nav_code = NAV_GEO_POS;
                NAV_ID_SOL:     nav_code = NAV_SOL;
                NAV_ID_VELNED:  nav_code = NAV_VELNED;
                NAV_ID_SVINFO:  nav_code = NAV_SVINFO;
                NAV_ID_STATUS:  nav_code = NAV_STATUS;
                NAV_ID_CLOCK:   nav_code = NAV_CLOCK;
                default:        nav_code = NAV_OTHER;
            endcase
        end
    end

    // advance whenever the output register is free or being emptied
    assign q_pop = !q_empty && (!valid_reg || res.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg  <= q_data.kind;
            class_reg <= q_data.msg_class;
            id_reg    <= q_data.msg_id;
            index_reg <= q_data.index;
            data_reg  <= q_data.data;
            len_reg   <= q_data.length;
            nav_reg   <= nav_code;
        end
    end

    assign res.valid          = valid_reg;
    assign res.result_kind    = kind_reg;
    assign res.msg_class      = class_reg;
    assign res.msg_id         = id_reg;
    assign res.payload_index  = index_reg;
    assign res.payload_byte   = data_reg;
    assign res.payload_length = len_reg;
    assign res.nav_message    = nav_reg;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UBX frame deframer. A short table of directed
// bytes covers sync handling, empty, oversized and corrupted frames; random
// frames, broken syncs and line noise follow under several register
// settings and three idling patterns. Every accepted result is checked field
// by field against an in-bench parser model fed with the accepted bytes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ufd_pkg::*;

    // Quiet cycles tolerated before the run is declared hung. The longest
    // correct gap is a run of idle cycles at 76 percent, well under this.
    localparam int STALL_LIMIT     = 2000;
    // Results pass a four-entry queue and the output register; hold this long.
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int NUM_PHASES      = 6;
    localparam int DIR_ROWS        = 27;

    // One result item as the block should present it.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] index;
        logic [7:0]  data;
        logic [15:0] length;
        nav_t        nav;
    } frame_event_t;

    // A directed byte; where typed is set, the result it ends is given here.
    typedef struct packed {
        logic [7:0]   rx_byte;
        logic         typed;
        frame_event_t result;
    } dir_row_t;

    // Register values and idling pattern for one random phase.
    typedef struct packed {
        logic [15:0] max_len;
        logic [7:0]  nav_cls;
        logic [7:0]  send_idle;
        logic [7:0]  recv_idle;
    } phase_cfg_t;

    localparam frame_event_t NO_EVENT = '0;

    logic clk = 1'b0;
    logic rst_n;

    ufd_byte_if   rx_if ();
    ufd_result_if res_if ();
    ufd_cfg_if    cfg_if ();

    ubx_frame_deframer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Directed stimulus. Fletcher sums for the typed rows:
    //   01 02 00 00      -> A 0x03, B 0x0A (good, empty payload)
    //   01 06 01 00 FF   -> A 0x07, B 0x1F (check bytes 00 00 are bad)
    //   length 0x03E1 = 993 exceeds the reset limit of 992
    // ------------------------------------------------------------------
    dir_row_t dir_table [DIR_ROWS] = '{
        '{8'h00, 1'b0, NO_EVENT},       // garbage while hunting
        '{8'hB5, 1'b0, NO_EVENT},
        '{8'hB5, 1'b0, NO_EVENT},       // repeated first sync byte
        '{8'h62, 1'b0, NO_EVENT},
        '{8'h01, 1'b0, NO_EVENT},       // nav class at reset
        '{8'h02, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},       // empty payload
        '{8'h03, 1'b0, NO_EVENT},
        '{8'h0A, 1'b1, '{KIND_GOOD, 8'h01, 8'h02, 16'd0, 8'h00, 16'd0, NAV_GEO_POS}},
        '{8'hB5, 1'b0, NO_EVENT},
        '{8'h62, 1'b0, NO_EVENT},
        '{8'hFF, 1'b0, NO_EVENT},
        '{8'hFF, 1'b0, NO_EVENT},
        '{8'hE1, 1'b0, NO_EVENT},
        '{8'h03, 1'b1, '{KIND_LONG, 8'hFF, 8'hFF, 16'd0, 8'h00, 16'd993, NAV_OTHER}},
        '{8'hB5, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},       // broken sync, back to hunting
        '{8'hB5, 1'b0, NO_EVENT},
        '{8'h62, 1'b0, NO_EVENT},
        '{8'h01, 1'b0, NO_EVENT},
        '{8'h06, 1'b0, NO_EVENT},
        '{8'h01, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},
        '{8'hFF, 1'b0, NO_EVENT},       // single payload byte, from the model
        '{8'h00, 1'b0, NO_EVENT},
        '{8'h00, 1'b1, '{KIND_BAD, 8'h01, 8'h06, 16'd0, 8'h00, 16'd1, NAV_SOL}}
    };

    // Register extremes first, then ordinary values; receiver-heavy idling,
    // then sender-heavy, then none.
    phase_cfg_t phase_table [NUM_PHASES] = '{
        '{16'd8,     8'h01, 8'd30, 8'd76},
        '{16'd0,     8'h00, 8'd30, 8'd76},
        '{16'hFFFF,  8'hFF, 8'd76, 8'd30},
        '{16'd3,     8'h5A, 8'd76, 8'd30},
        '{16'd992,   8'h01, 8'd0,  8'd0},
        '{16'h0100,  8'h02, 8'd0,  8'd0}
    };

    // Parser model state and its copy of the registers.
    phase_t      pm_phase;
    logic [7:0]  pm_class;
    logic [7:0]  pm_id;
    logic [15:0] pm_length;
    logic [15:0] pm_count;
    logic [7:0]  pm_sum_a;
    logic [7:0]  pm_sum_b;
    logic [7:0]  pm_ck_a;
    logic [15:0] cfg_max_len;
    logic [7:0]  cfg_nav_cls;

    frame_event_t expected_events [$];
    logic [7:0]   byte_script [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic void fold_sum(input logic [7:0] b);
        pm_sum_a = pm_sum_a + b;
        pm_sum_b = pm_sum_b + pm_sum_a;
    endfunction

    function automatic frame_event_t make_event(input kind_t kind, input logic [15:0] idx,
                                                input logic [7:0] data);
        frame_event_t ev;
        ev.kind      = kind;
        ev.msg_class = pm_class;
        ev.msg_id    = pm_id;
        ev.index     = idx;
        ev.data      = data;
        ev.length    = pm_length;
        ev.nav       = NAV_OTHER;
        if (pm_class == cfg_nav_cls)
        begin
            case (pm_id)
                NAV_ID_GEO_POS: ev.nav = NAV_GEO_POS;
                NAV_ID_SOL:     ev.nav = NAV_SOL;
                NAV_ID_VELNED:  ev.nav = NAV_VELNED;
                NAV_ID_SVINFO:  ev.nav = NAV_SVINFO;
                NAV_ID_STATUS:  ev.nav = NAV_STATUS;
                NAV_ID_CLOCK:   ev.nav = NAV_CLOCK;
                default:        ev.nav = NAV_OTHER;
            endcase
        end
        return ev;
    endfunction

    // Advance the parser model by one accepted byte; return 1 with the
    // result when the byte produces one.
    function automatic bit parse_byte(input logic [7:0] b, output frame_event_t ev);
        bit has_result;
        has_result = 1'b0;
        ev = NO_EVENT;
        case (pm_phase)
            PH_HUNT1:
                if (b == SYNC_FIRST)
                    pm_phase = PH_HUNT2;
            PH_HUNT2:
                if (b == SYNC_SECOND)
                begin
                    pm_sum_a = '0;
                    pm_sum_b = '0;
                    pm_phase = PH_CLASS;
                end
                else if (b != SYNC_FIRST)
                    pm_phase = PH_HUNT1;
            PH_CLASS:
            begin
                pm_class = b;
                fold_sum(b);
                pm_phase = PH_ID;
            end
            PH_ID:
            begin
                pm_id = b;
                fold_sum(b);
                pm_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                pm_length = {8'h00, b};
                fold_sum(b);
                pm_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                pm_length = {b, pm_length[7:0]};
                fold_sum(b);
                pm_count = '0;
                if (pm_length > cfg_max_len)
                begin
                    ev = make_event(KIND_LONG, 16'd0, 8'h00);
                    has_result = 1'b1;
                    pm_phase = PH_HUNT1;
                end
                else
                    pm_phase = (pm_length == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                ev = make_event(KIND_PAYLOAD, pm_count, b);
                has_result = 1'b1;
                fold_sum(b);
                pm_count = pm_count + 16'd1;
                if (pm_count >= pm_length)
                    pm_phase = PH_CK_A;
            end
            PH_CK_A:
            begin
                pm_ck_a = b;
                pm_phase = PH_CK_B;
            end
            PH_CK_B:
            begin
                ev = make_event((pm_ck_a == pm_sum_a && b == pm_sum_b) ? KIND_GOOD : KIND_BAD,
                                16'd0, 8'h00);
                has_result = 1'b1;
                pm_phase = PH_HUNT1;
            end
            default:
                pm_phase = PH_HUNT1;
        endcase
        return has_result;
    endfunction

    // Offer one byte, idling first as the current pattern says; on acceptance
    // record the result it causes (the typed one for marked table rows).
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input frame_event_t typed_ev);
        frame_event_t ev;
        bit has_result;
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        has_result = parse_byte(b, ev);
        if (typed)
            expected_events.push_back(typed_ev);
        else if (has_result)
            expected_events.push_back(ev);
    endtask

    // Drop valid and hold until every result is back and the pipe is empty.
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; only called while idle.
    task automatic write_settings(input logic [15:0] max_len, input logic [7:0] nav_cls);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_MAX_LEN;
        cfg_if.data  <= max_len;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_max_len = max_len;
        cfg_if.index <= CFG_NAV_CLASS;
        cfg_if.data  <= {8'h00, nav_cls};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_nav_cls = nav_cls;
        cfg_if.valid <= 1'b0;
    endtask

    // Queue up one random sequence: mostly whole frames with random content,
    // some broken syncs, some noise. Noise does not count towards the total.
    task automatic compose_sequence(output int counted);
        logic [7:0]  nav_ids [6] = '{NAV_ID_GEO_POS, NAV_ID_SOL, NAV_ID_VELNED,
                                     NAV_ID_SVINFO, NAV_ID_STATUS, NAV_ID_CLOCK};
        logic [7:0]  hdr [4];
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [7:0]  b;
        logic [15:0] len;
        int          choice;
        int          span;
        int          lim;
        bit          too_long;
        choice = $urandom_range(99);
        counted = 0;
        if (choice < 70)
        begin
            if ($urandom_range(9) == 0)
                byte_script.push_back(SYNC_FIRST);
            hdr[0] = $urandom_range(1) ? cfg_nav_cls : 8'($urandom_range(255));
            hdr[1] = $urandom_range(1) ? nav_ids[$urandom_range(5)] : 8'($urandom_range(255));
            too_long = (cfg_max_len != 16'hFFFF) && ($urandom_range(99) < 15);
            if (too_long)
            begin
                span = 65535 - int'(cfg_max_len);
                if ($urandom_range(1))
                    len = cfg_max_len + 16'd1 + 16'($urandom_range((span > 3) ? 3 : span - 1));
                else
                    len = cfg_max_len + 16'd1 + 16'($urandom_range(span - 1));
            end
            else
            begin
                lim = (cfg_max_len < 16'd6) ? int'(cfg_max_len) : 6;
                if ($urandom_range(19) == 0 && cfg_max_len >= 16'd40)
                    lim = 40;
                len = 16'($urandom_range(lim));
            end
            hdr[2] = len[7:0];
            hdr[3] = len[15:8];
            byte_script.push_back(SYNC_FIRST);
            byte_script.push_back(SYNC_SECOND);
            ck_a = '0;
            ck_b = '0;
            foreach (hdr[i])
            begin
                byte_script.push_back(hdr[i]);
                ck_a = ck_a + hdr[i];
                ck_b = ck_b + ck_a;
            end
            if (too_long)
            begin
                // leftovers of the dropped frame are hunted through
                repeat ($urandom_range(3))
                    byte_script.push_back(8'($urandom_range(255)));
            end
            else
            begin
                repeat (len)
                begin
                    b = 8'($urandom_range(255));
                    byte_script.push_back(b);
                    ck_a = ck_a + b;
                    ck_b = ck_b + ck_a;
                end
                // corrupt one check byte now and then
                if ($urandom_range(4) == 0)
                begin
                    if ($urandom_range(1))
                        ck_a = ck_a ^ 8'($urandom_range(255, 1));
                    else
                        ck_b = ck_b ^ 8'($urandom_range(255, 1));
                end
                byte_script.push_back(ck_a);
                byte_script.push_back(ck_b);
            end
            counted = byte_script.size();
        end
        else if (choice < 85)
        begin
            // broken sync: first sync byte, maybe repeated, then anything else
            repeat ($urandom_range(3, 1))
                byte_script.push_back(SYNC_FIRST);
            do
                b = 8'($urandom_range(255));
            while (b == SYNC_SECOND || b == SYNC_FIRST);
            byte_script.push_back(b);
            counted = byte_script.size();
        end
        else
        begin
            repeat ($urandom_range(4, 1))
                byte_script.push_back(8'($urandom_range(255)));
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        frame_event_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_events.size() == 0)
                report_mismatch($sformatf("result kind %0d with nothing expected",
                                          res_if.result_kind));
            else
            begin
                want = expected_events.pop_front();
                check_field("result_kind",    16'(res_if.result_kind),    16'(want.kind));
                check_field("msg_class",      16'(res_if.msg_class),      16'(want.msg_class));
                check_field("msg_id",         16'(res_if.msg_id),         16'(want.msg_id));
                check_field("payload_index",  res_if.payload_index,       want.index);
                check_field("payload_byte",   16'(res_if.payload_byte),   16'(want.data));
                check_field("payload_length", res_if.payload_length,      want.length);
                check_field("nav_message",    16'(res_if.nav_message),    16'(want.nav));
            end
        end
    end

    // Watchdog: end the run when no channel moves an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int items;
        int counted;
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = 8'h00;
        res_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = CFG_MAX_LEN;
        cfg_if.data    = 16'h0000;
        pm_phase       = PH_HUNT1;
        pm_class       = '0;
        pm_id          = '0;
        pm_length      = '0;
        pm_count       = '0;
        pm_sum_a       = '0;
        pm_sum_b       = '0;
        pm_ck_a        = '0;
        cfg_max_len    = MAX_LEN_RESET;
        cfg_nav_cls    = NAV_CLASS_RESET;
        send_idle_pct  = phase_table[0].send_idle;
        recv_idle_pct  = phase_table[0].recv_idle;
        mismatches     = 0;

        // Receiver: stall at the current rate.
        fork
            begin : ready_driver
                forever
                begin
                    @(posedge clk);
                    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
                end
            end
        join_none

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset register values.
        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(dir_table[i].rx_byte, dir_table[i].typed, dir_table[i].result);
        settle();

        // Random part, one register setting and idling pattern per phase.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = phase_table[p].send_idle;
            recv_idle_pct = phase_table[p].recv_idle;
            write_settings(phase_table[p].max_len, phase_table[p].nav_cls);
            items = 0;
            while (items < ITEMS_PER_PHASE)
            begin
                compose_sequence(counted);
                items += counted;
                while (byte_script.size() != 0)
                    send_byte(byte_script.pop_front(), 1'b0, NO_EVENT);
            end
            settle();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
